// File: sv/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int DEF_NUM_BLOCKS = 16;
  localparam int DEF_SIZE_BITS  = 16;
  localparam int FIELD_W        = 16;
  localparam int BLOCK_NUM_W    = 5;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic load;
    logic capture;
    logic step;
    logic finish;
  } ffba_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } ffba_sts_t;

endpackage

// File: sv/ffba_datapath.sv
// Block table, free bits, scan pipeline and result registers.
`timescale 1ns / 1ps
module ffba_datapath
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ffba_cmd_t              cmd,
  output ffba_sts_t              sts,
  input  logic [FIELD_W-1:0]     size_value,
  input  logic                   last_request,
  output logic                   allocated,
  output logic [BLOCK_NUM_W-1:0] block_number,
  output logic [FIELD_W-1:0]     chosen_size,
  output logic [FIELD_W-1:0]     fragment,
  output logic [FIELD_W-1:0]     request_echo,
  output logic                   last_flag
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic [SIZE_BITS-1:0]  sizes [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] free_bits;
  logic [CNT_W-1:0]      loaded;
  logic [SIZE_BITS-1:0]  req_size;
  logic [FIELD_W-1:0]    req_echo;
  logic                  req_last;
  logic [CNT_W-1:0]      iss;
  logic [SIZE_BITS-1:0]  rd_data;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_valid;

  logic [31:0]          size_wide;
  logic [SIZE_BITS-1:0] size_in;
  logic [31:0]          echo_wide;
  logic                 can_load;
  logic                 can_issue;
  logic                 cand_ok;
  logic [SIZE_BITS-1:0] diff;
  logic [31:0]          size_out_wide;
  logic [31:0]          diff_wide;
  logic [IDX_W:0]       bn;
  logic [31:0]          bn_wide;

  assign size_wide     = {16'b0, size_value};
  assign size_in       = size_wide[SIZE_BITS-1:0];
  assign echo_wide     = 32'(size_in);
  assign can_load      = loaded < CNT_W'(NUM_BLOCKS);
  assign can_issue     = iss < loaded;
  assign cand_ok       = rd_valid && free_bits[rd_idx] && (rd_data >= req_size);
  assign diff          = rd_data - req_size;
  assign size_out_wide = 32'(rd_data);
  assign diff_wide     = 32'(diff);
  assign bn            = {1'b0, rd_idx} + 1'b1;
  assign bn_wide       = 32'(bn);

  assign sts.hit       = cand_ok;
  assign sts.exhausted = !rd_valid && !can_issue;

  // table storage
  always_ff @(posedge clk) begin
    if (cmd.load && can_load) begin
      sizes[loaded[IDX_W-1:0]] <= size_in;
    end
    if (cmd.step && can_issue) begin
      rd_data <= sizes[iss[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_bits <= '0;
      loaded    <= '0;
      iss       <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.load && can_load) begin
        free_bits[loaded[IDX_W-1:0]] <= 1'b1;
        loaded <= loaded + 1'b1;
      end
      if (cmd.capture) begin
        iss      <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.step) begin
        rd_valid <= can_issue;
        if (can_issue) begin
          iss <= iss + 1'b1;
        end
      end
      if (cmd.finish && cand_ok) begin
        free_bits[rd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_size <= size_in;
      req_echo <= echo_wide[FIELD_W-1:0];
      req_last <= last_request;
    end
    if (cmd.step && can_issue) begin
      rd_idx <= iss[IDX_W-1:0];
    end
    if (cmd.finish) begin
      allocated    <= cand_ok;
      block_number <= cand_ok ? bn_wide[BLOCK_NUM_W-1:0] : '0;
      chosen_size  <= cand_ok ? size_out_wide[FIELD_W-1:0] : '0;
      fragment     <= cand_ok ? diff_wide[FIELD_W-1:0] : '0;
      request_echo <= req_echo;
      last_flag    <= req_last;
    end
  end

endmodule

// File: sv/ffba_ctrl.sv
// Controller state machine: accepts items, runs the table scan, fires the result strobe.
`timescale 1ns / 1ps
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      kind,
  input  ffba_sts_t sts,
  output ffba_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.load    = (state == S_IDLE) && start && (kind == KIND_LOAD);
    cmd.capture = (state == S_IDLE) && start && (kind == KIND_REQUEST);
    cmd.step    = (state == S_SCAN);
    cmd.finish  = (state == S_SCAN) && (sts.hit || sts.exhausted);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd.finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= cmd.finish;
    end
  end

endmodule

// File: sv/first_fit_block_allocator.sv
// Top level of the first-fit fixed-partition block allocator.
// Usage:
//   An item transfers at a rising edge with start high and busy low.
//   kind = load appends size_value to the block table and marks the block free;
//   loads past NUM_BLOCKS entries are dropped. A load gives no result and leaves
//   busy low.
//   kind = request searches loaded blocks from number 1 upward for the first free
//   block at least size_value large, claims it and reports it. busy rises for the
//   scan; the result shows for exactly one cycle with done high, and the receiver
//   cannot stall it. block_number is 1-based, 0 with allocated low if no fit.
// Scan: the scan reads one table entry per cycle from the size memory
//   (registered read, then a combinational compare). The next item can
//   transfer in the cycle done is high.
// Reset: synchronous rst empties the table (all blocks used, count zero).
`timescale 1ns / 1ps
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [FIELD_W-1:0]     size_value,
  input  logic                   last_request,
  output logic                   done,
  output logic                   allocated,
  output logic [BLOCK_NUM_W-1:0] block_number,
  output logic [FIELD_W-1:0]     chosen_size,
  output logic [FIELD_W-1:0]     fragment,
  output logic [FIELD_W-1:0]     request_echo,
  output logic                   last_flag
);

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ffba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .size_value   (size_value),
    .last_request (last_request),
    .allocated    (allocated),
    .block_number (block_number),
    .chosen_size  (chosen_size),
    .fragment     (fragment),
    .request_echo (request_echo),
    .last_flag    (last_flag)
  );

endmodule
